// ===== src/rmst_pkg.sv =====
// Shared constants for the range maximum segment tree.
// No dependencies; every other file in this block imports it.
package rmst_pkg;

    localparam int FIELD_W     = 32;
    localparam int INDEX_W     = 10;
    localparam int USED_W      = 11;
    localparam int CFG_INDEX_W = 1;

    localparam logic FUNC_UPDATE = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_USED_LEAVES = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_EMPTY_VALUE = 1'b1;

    localparam logic signed [FIELD_W-1:0] VALUE_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

endpackage

// ===== src/rmst_req_if.sv =====
// Request channel of the segment tree: one update or query per transfer.
// Depends on rmst_pkg for field widths.
interface rmst_req_if
    import rmst_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      func;
    logic [INDEX_W-1:0]        first_index;
    logic [INDEX_W-1:0]        last_index;
    logic signed [FIELD_W-1:0] new_value;

    modport source (output valid, func, first_index, last_index, new_value, input ready);
    modport sink   (input valid, func, first_index, last_index, new_value, output ready);
endinterface

// ===== src/rmst_rsp_if.sv =====
// Response channel of the segment tree: one result per request.
// Depends on rmst_pkg for field widths.
interface rmst_rsp_if
    import rmst_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] max_value;
    logic                      index_error;

    modport source (output valid, max_value, index_error, input ready);
    modport sink   (input valid, max_value, index_error, output ready);
endinterface

// ===== src/rmst_cfg_if.sv =====
// Configuration write channel of the segment tree.
// Depends on rmst_pkg for the register index width.
interface rmst_cfg_if
    import rmst_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] reg_index;
    logic [FIELD_W-1:0]     data;

    modport source (output valid, reg_index, data, input ready);
    modport sink   (input valid, reg_index, data, output ready);
endinterface

// ===== src/range_max_segment_tree.sv =====
// Range maximum segment tree: point update and inclusive range maximum query.
// An update writes the leaf and each ancestor up to the root; a query walks both range ends
// up the tree level by level; an index error or an empty range goes straight to the result.
// One item at a time: no new request is taken until the last result moves to the output.
// Reset: asynchronous clear of control, then a clearing pass zeroes every node address
// while no request is taken (configuration writes are taken as ever).
module range_max_segment_tree
    import rmst_pkg::*;
#(
    parameter int LEAVES = 1024
)(
    input  logic       clk,
    input  logic       rst_n,
    rmst_req_if.sink   req,
    rmst_rsp_if.source rsp,
    rmst_cfg_if.sink   cfg
);

    // Node k lives at address k; leaves sit at LEAVES..2*LEAVES-1, node 0 unused.
    localparam int ADDR_W = $clog2(2 * LEAVES);
    // Query pointers can reach 2*LEAVES, so carry one more bit.
    localparam int PTR_W  = ADDR_W + 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(2 * LEAVES - 1);
    localparam logic [PTR_W-1:0]  LEAF_BASE = PTR_W'(LEAVES);
    localparam logic [PTR_W-1:0]  ROOT_PTR  = PTR_W'(1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_UPD_RD = 3'd1;
    localparam logic [2:0] S_UPD_MG = 3'd2;
    localparam logic [2:0] S_QRY_RD = 3'd3;
    localparam logic [2:0] S_QRY_MG = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    // Node memory: one write port, two registered read ports.
    logic signed [FIELD_W-1:0] node_mem [2*LEAVES];
    logic                      mem_we;
    logic [ADDR_W-1:0]         mem_waddr;
    logic signed [FIELD_W-1:0] mem_wdata;
    logic [ADDR_W-1:0]         rd_addr_a;
    logic [ADDR_W-1:0]         rd_addr_b;
    logic signed [FIELD_W-1:0] rd_a_reg;
    logic signed [FIELD_W-1:0] rd_b_reg;

    logic [2:0]                state_reg, state_next;
    logic [PTR_W-1:0]          l_reg, l_next;
    logic [PTR_W-1:0]          r_reg, r_next;
    logic signed [FIELD_W-1:0] acc_reg, acc_next;
    logic                      hit_a_reg, hit_a_next;
    logic                      hit_b_reg, hit_b_next;
    logic                      err_reg, err_next;

    logic                      out_valid_reg, out_valid_next;
    logic signed [FIELD_W-1:0] out_max_reg;
    logic                      out_err_reg;
    logic                      out_load;

    logic                      clearing_reg;
    logic [ADDR_W-1:0]         clr_cnt_reg;

    logic [USED_W-1:0]         used_leaves_reg;
    logic signed [FIELD_W-1:0] empty_value_reg;

    logic                      req_xfer;
    logic                      lo_bad;
    logic                      hi_bad;
    logic signed [FIELD_W-1:0] cand_a;
    logic signed [FIELD_W-1:0] cand_b;
    logic signed [FIELD_W-1:0] merge_ab;

    // ------------------------------------------------------------------
    // Configuration: always ready; the user must write it only while the block is idle, unchecked here.
    // ------------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_leaves_reg <= USED_W'(1024);
            empty_value_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.reg_index)
                REG_USED_LEAVES: used_leaves_reg <= cfg.data[USED_W-1:0];
                REG_EMPTY_VALUE: empty_value_reg <= cfg.data;
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Range checks against min(used_leaves, LEAVES), split into two compares.
    // ------------------------------------------------------------------
    assign lo_bad = ({1'b0, req.first_index} >= used_leaves_reg) ||
                    ({22'd0, req.first_index} >= 32'(LEAVES));
    assign hi_bad = ({1'b0, req.last_index} >= used_leaves_reg) ||
                    ({22'd0, req.last_index} >= 32'(LEAVES));

    assign req.ready = (state_reg == S_IDLE) && !clearing_reg;
    assign req_xfer  = req.valid && req.ready;

    // Candidates for the query merge; a port not read contributes the minimum.
    assign cand_a   = hit_a_reg ? rd_a_reg : VALUE_MIN;
    assign cand_b   = hit_b_reg ? rd_b_reg : VALUE_MIN;
    assign merge_ab = (cand_a > cand_b) ? cand_a : cand_b;

    // ------------------------------------------------------------------
    // Sequencer: walk the tree one level per read/merge pair.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        l_next     = l_reg;
        r_next     = r_reg;
        acc_next   = acc_reg;
        hit_a_next = hit_a_reg;
        hit_b_next = hit_b_reg;
        err_next   = err_reg;
        rd_addr_a  = l_reg[ADDR_W-1:0];
        rd_addr_b  = '0;
        mem_we     = 1'b0;
        mem_waddr  = l_reg[ADDR_W-1:0];
        mem_wdata  = acc_reg;
        out_load   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    l_next   = LEAF_BASE + PTR_W'(req.first_index);
                    r_next   = LEAF_BASE + PTR_W'(req.last_index) + PTR_W'(1);
                    err_next = 1'b0;
                    if (req.func == FUNC_UPDATE)
                    begin
                        acc_next = req.new_value;
                        if (lo_bad)
                        begin
                            acc_next   = '0;
                            err_next   = 1'b1;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_UPD_RD;
                        end
                    end
                    else if (lo_bad || hi_bad)
                    begin
                        acc_next   = '0;
                        err_next   = 1'b1;
                        state_next = S_DONE;
                    end
                    else if (req.first_index > req.last_index)
                    begin
                        acc_next   = empty_value_reg;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        acc_next   = VALUE_MIN;
                        state_next = S_QRY_RD;
                    end
                end
            end

            S_UPD_RD:
            begin
                // Write the current node, fetch its sibling for the parent merge.
                mem_we    = 1'b1;
                rd_addr_a = {l_reg[ADDR_W-1:1], ~l_reg[0]};
                if (l_reg == ROOT_PTR)
                begin
                    acc_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_UPD_MG;
                end
            end

            S_UPD_MG:
            begin
                acc_next   = (rd_a_reg > acc_reg) ? rd_a_reg : acc_reg;
                l_next     = l_reg >> 1;
                state_next = S_UPD_RD;
            end

            S_QRY_RD:
            begin
                if (l_reg >= r_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    // Odd left takes node l, odd right takes node r-1.
                    rd_addr_a  = l_reg[ADDR_W-1:0];
                    rd_addr_b  = ADDR_W'(r_reg - PTR_W'(1));
                    hit_a_next = l_reg[0];
                    hit_b_next = r_reg[0];
                    l_next     = (l_reg + PTR_W'(l_reg[0])) >> 1;
                    r_next     = r_reg >> 1;
                    state_next = S_QRY_MG;
                end
            end

            S_QRY_MG:
            begin
                acc_next   = (merge_ab > acc_reg) ? merge_ab : acc_reg;
                state_next = S_QRY_RD;
            end

            S_DONE:
            begin
                // Hold the result until the output register is free.
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // The clearing pass owns the write port.
        if (clearing_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            clearing_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    clearing_reg <= 1'b0;
                end
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        l_reg     <= l_next;
        r_reg     <= r_next;
        acc_reg   <= acc_next;
        hit_a_reg <= hit_a_next;
        hit_b_reg <= hit_b_next;
        err_reg   <= err_next;
        if (out_load)
        begin
            out_max_reg <= acc_reg;
            out_err_reg <= err_reg;
        end
    end

    // ------------------------------------------------------------------
    // Node memory.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            node_mem[mem_waddr] <= mem_wdata;
        end
        rd_a_reg <= node_mem[rd_addr_a];
        rd_b_reg <= node_mem[rd_addr_b];
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.max_value   = out_max_reg;
    assign rsp.index_error = out_err_reg;

`ifndef ASSERT_OFF
    // No request transfer while the clearing pass runs.
    a_no_req_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !req.ready)
        else $error("request taken during clearing pass");

    // Only the clearing pass and the update walk write the node memory.
    a_write_owner: assert property (
        @(posedge clk) disable iff (!rst_n)
        mem_we |-> (clearing_reg || state_reg == S_UPD_RD))
        else $error("node memory written outside update or clear");

    // The update walk never addresses node zero.
    a_upd_ptr_nonzero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD_RD) |-> (l_reg != '0))
        else $error("update walk reached node zero");

    // An erroneous result always carries a zero maximum.
    a_err_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.index_error) |-> (rsp.max_value == '0))
        else $error("index error with non-zero maximum");
`endif

endmodule

// ===== test/rmst_checker.sv =====
// Checker for the range maximum segment tree: watches the request, response and
// configuration channels, predicts every result and compares it on arrival.
// Depends on rmst_pkg and the three channel interfaces.
module rmst_checker
    import rmst_pkg::*;
#(
    parameter int LEAVES = 1024
)(
    input  logic clk,
    input  logic rst_n,
    rmst_req_if  req,
    rmst_rsp_if  rsp,
    rmst_cfg_if  cfg,
    output int   mismatch_count,
    output int   results_pending
);

    typedef struct packed {
        logic signed [FIELD_W-1:0] max_value;
        logic                      index_error;
    } tree_result_t;

    logic signed [FIELD_W-1:0] leaf_value [LEAVES];
    logic [USED_W-1:0]         used_leaves;
    logic signed [FIELD_W-1:0] empty_value;
    tree_result_t              expected_results [$];
    tree_result_t              predicted;
    tree_result_t              oldest;

    task automatic report_mismatch(input string what);
        $display("%0t: mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // The maximum over a range does not depend on the tree's shape, so keep
    // only the leaves and scan them.
    function automatic tree_result_t predict_result(input logic func,
                                                   input logic [INDEX_W-1:0] first,
                                                   input logic [INDEX_W-1:0] last,
                                                   input logic signed [FIELD_W-1:0] value);
        tree_result_t              r;
        int                        size;
        int                        lo;
        int                        hi;
        logic signed [FIELD_W-1:0] best;
        r.max_value   = '0;
        r.index_error = 1'b0;
        size = (int'(used_leaves) > LEAVES) ? LEAVES : int'(used_leaves);
        lo   = int'(first);
        hi   = int'(last);
        if (func == FUNC_UPDATE)
        begin
            if (lo >= size)
                r.index_error = 1'b1;
            else
                leaf_value[lo] = value;
        end
        else if (lo >= size || hi >= size)
        begin
            r.index_error = 1'b1;
        end
        else if (lo > hi)
        begin
            r.max_value = empty_value;
        end
        else
        begin
            best = VALUE_MIN;
            for (int i = lo; i <= hi; i++)
                if (leaf_value[i] > best)
                    best = leaf_value[i];
            r.max_value = best;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (leaf_value[i])
                leaf_value[i] = '0;
            used_leaves = USED_W'(1024);
            empty_value = '0;
            expected_results.delete();
            results_pending <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.reg_index)
                    REG_USED_LEAVES: used_leaves = cfg.data[USED_W-1:0];
                    REG_EMPTY_VALUE: empty_value = cfg.data;
                    default: ;
                endcase
            end
            // Retire results before adding new expectations from this edge.
            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch($sformatf("result %0d/%b with nothing outstanding",
                                              rsp.max_value, rsp.index_error));
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    if (rsp.max_value !== oldest.max_value)
                        report_mismatch($sformatf("max_value %0d, predicted %0d",
                                                  rsp.max_value, oldest.max_value));
                    if (rsp.index_error !== oldest.index_error)
                        report_mismatch($sformatf("index_error %b, predicted %b",
                                                  rsp.index_error, oldest.index_error));
                end
            end
            if (req.valid && req.ready)
            begin
                predicted = predict_result(req.func, req.first_index,
                                           req.last_index, req.new_value);
                expected_results.push_back(predicted);
            end
            results_pending <= expected_results.size();
        end
    end

endmodule

// ===== test/tb_top.sv =====
// Top of the segment tree testbench: clock, reset, stimulus and verdict.
// Depends on rmst_pkg, the channel interfaces, range_max_segment_tree and rmst_checker.
module tb_top
    import rmst_pkg::*;
();

    localparam int LEAVES         = 1024;
    // Longest quiet stretch is the clearing pass after reset; allow that plus the
    // longest stall, gap and latency several times over.
    localparam int WATCHDOG_LIMIT = 6000;
    // Settle for longer than the slowest item, a full-range query, takes to finish.
    localparam int SETTLE_CYCLES  = 40;

    logic clk = 1'b0;
    logic rst_n;

    int   mismatch_count;
    int   results_pending;
    int   idle_cycles = 0;
    int   tree_size;      // effective size for the current setting
    bit   sender_calm;    // hold valid without gaps while set

    rmst_req_if req_ch ();
    rmst_rsp_if rsp_ch ();
    rmst_cfg_if cfg_ch ();

    range_max_segment_tree #(.LEAVES(LEAVES)) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    rmst_checker #(.LEAVES(LEAVES)) checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .req             (req_ch),
        .rsp             (rsp_ch),
        .cfg             (cfg_ch),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: count cycles without any transfer on any channel.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Gap or stall length: mostly none, sometimes short, rarely long.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Response side: stall at random, with calm stretches where ready stays high.
    initial
    begin
        int  stall;
        int  calm_left;
        bit  calm;
        stall     = 0;
        calm_left = 0;
        calm      = 1'b0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (calm_left == 0)
            begin
                calm      = ($urandom_range(0, 3) == 0);
                calm_left = $urandom_range(50, 300);
            end
            calm_left--;
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (!calm)
                    stall = idle_length();
            end
        end
    end

    // Present one request and hold it until the transfer. A gap lowers valid
    // first; with no gap valid stays high straight into the next request.
    task automatic send_item(input logic func, input int first, input int last,
                             input logic signed [FIELD_W-1:0] value);
        int gap;
        gap = sender_calm ? 0 : idle_length();
        @(negedge clk);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.func        <= func;
        req_ch.first_index <= first[INDEX_W-1:0];
        req_ch.last_index  <= last[INDEX_W-1:0];
        req_ch.new_value   <= value;
        do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
    endtask

    // Drop valid and wait until every predicted result has arrived.
    task automatic drain();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [FIELD_W-1:0] data);
        @(negedge clk);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= index;
        cfg_ch.data      <= data;
        do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Write both registers; only ever called while the block is idle.
    task automatic configure(input int used, input logic signed [FIELD_W-1:0] empty_val);
        write_reg(REG_USED_LEAVES, FIELD_W'(used));
        write_reg(REG_EMPTY_VALUE, empty_val);
        tree_size = (used > LEAVES) ? LEAVES : used;
    endtask

    // Mostly a legal index, now and then one at or beyond the used size.
    function automatic int pick_index();
        if (tree_size == 0)
            return $urandom_range(0, LEAVES - 1);
        if (tree_size < LEAVES && $urandom_range(0, 9) == 0)
            return $urandom_range(tree_size, LEAVES - 1);
        return $urandom_range(0, tree_size - 1);
    endfunction

    function automatic logic signed [FIELD_W-1:0] random_value();
        case ($urandom_range(0, 9))
            0: return VALUE_MIN;
            1: return 32'h7fff_ffff;
            2: return '0;
            3: return $signed($urandom_range(0, 20)) - 10;
            default: return $urandom;
        endcase
    endfunction

    // Random phase: a mix of updates and queries, most queries well formed
    // with short, long and full ranges, some empty or out of range.
    task automatic run_random(input int count);
        int   lo;
        int   hi;
        logic func;
        for (int n = 0; n < count; n++)
        begin
            if (n % 50 == 0)
                sender_calm = ($urandom_range(0, 3) == 0);
            func = ($urandom_range(0, 99) < 45) ? FUNC_UPDATE : FUNC_QUERY;
            lo   = pick_index();
            hi   = $urandom_range(0, LEAVES - 1);
            if (func == FUNC_QUERY)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3:
                    begin
                        hi = lo + $urandom_range(0, 7);
                        if (lo < tree_size && hi >= tree_size)
                            hi = tree_size - 1;
                    end
                    7: hi = (lo > 0) ? $urandom_range(0, lo - 1) : 0;
                    8:
                    begin
                        lo = $urandom_range(0, 3);
                        hi = (tree_size > 0) ? tree_size - 1 : LEAVES - 1;
                    end
                    default: hi = pick_index();
                endcase
                if (hi > LEAVES - 1)
                    hi = LEAVES - 1;
            end
            send_item(func, lo, hi, random_value());
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.func        = FUNC_UPDATE;
        req_ch.first_index = '0;
        req_ch.last_index  = '0;
        req_ch.new_value   = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.reg_index   = REG_USED_LEAVES;
        cfg_ch.data        = '0;
        sender_calm        = 1'b0;
        tree_size          = LEAVES;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at full size: all-zero tree, extreme values at both
        // ends, empty ranges in both orders.
        configure(LEAVES, -5);
        send_item(FUNC_QUERY,  0,    1023, 0);
        send_item(FUNC_UPDATE, 0,    7,    VALUE_MIN);
        send_item(FUNC_QUERY,  0,    0,    0);
        send_item(FUNC_UPDATE, 1023, 0,    32'h7fff_ffff);
        send_item(FUNC_QUERY,  0,    1023, 0);
        send_item(FUNC_QUERY,  1023, 1023, 0);
        send_item(FUNC_UPDATE, 512,  1023, -1);
        send_item(FUNC_QUERY,  1,    1022, 0);
        send_item(FUNC_QUERY,  5,    3,    0);
        send_item(FUNC_QUERY,  1023, 0,    0);
        send_item(FUNC_UPDATE, 341,  682,  32'h5555_5555);
        drain();

        // Small size: out-of-range update and query, range error taking
        // precedence over an empty range.
        configure(10, VALUE_MIN);
        send_item(FUNC_UPDATE, 10, 0,  77);
        send_item(FUNC_UPDATE, 9,  0,  123);
        send_item(FUNC_QUERY,  0,  9,  0);
        send_item(FUNC_QUERY,  0,  10, 0);
        send_item(FUNC_QUERY,  10, 0,  0);
        send_item(FUNC_QUERY,  9,  0,  0);
        drain();

        // Zero size: every index is out of range.
        configure(0, 32'h7fff_ffff);
        send_item(FUNC_UPDATE, 0, 0, 1);
        send_item(FUNC_QUERY,  0, 0, 0);
        drain();

        // Oversized setting saturates; values written earlier persist.
        configure(2047, 32'h7fff_ffff);
        send_item(FUNC_QUERY, 0,    1023, 0);
        send_item(FUNC_QUERY, 1,    1022, 0);
        send_item(FUNC_QUERY, 1023, 5,    0);
        drain();

        // Random phases over a spread of settings, the extremes among them.
        configure(LEAVES, VALUE_MIN);
        run_random(270);
        drain();
        configure(2047, 32'h7fff_ffff);
        run_random(270);
        drain();
        configure(1, $urandom);
        run_random(200);
        drain();
        configure(2, 0);
        run_random(230);
        drain();
        configure(0, $urandom);
        run_random(60);
        drain();
        configure($urandom_range(3, 64), $urandom);
        run_random(300);
        drain();
        configure($urandom_range(65, LEAVES - 1), $urandom);
        run_random(300);
        drain();
        configure(LEAVES, $urandom);
        run_random(300);
        drain();

        // Let any stray result show before the verdict.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && results_pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
